/* sv/assert_macros.svh */
// assertion macros used by the rtl file rle_sprite_run_decoder.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the next cycle, outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rsrd_pkg.sv */
// package with phase codes, run kinds and opcodes of the sprite run decoder
package rsrd_pkg;

    typedef logic [2:0] t_phase;
    typedef logic [1:0] t_kind;

    localparam t_phase PH_OPCODE  = 3'd0;
    localparam t_phase PH_LITERAL = 3'd1;
    localparam t_phase PH_SHADOW1 = 3'd2;
    localparam t_phase PH_SHADOW2 = 3'd3;
    localparam t_phase PH_COUNT   = 3'd4;
    localparam t_phase PH_COLOR   = 3'd5;

    localparam t_kind KIND_COLOR  = 2'd0;
    localparam t_kind KIND_SHADOW = 2'd1;
    localparam t_kind KIND_END    = 2'd2;
    localparam t_kind KIND_RESV   = 2'd3;

    localparam logic [7:0] OP_END_ROW   = 8'h00;
    localparam logic [7:0] OP_END_IMAGE = 8'h80;
    localparam logic [7:0] OP_SHADOW    = 8'hC0;
    localparam logic [7:0] OP_COUNT     = 8'hC1;

    localparam int COORD_W   = 16;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 48;

endpackage

/* sv/rle_sprite_run_decoder.sv */
// run-length sprite decoder: one encoded byte in, at most one pixel run out
//
// The decoder takes one byte of the encoded sprite stream per cycle and keeps
// the cursor and parse phase in registers. Each byte is decoded by a single
// level of logic on the current state and its run, if any, is written into an
// output register, so a new byte is taken every cycle as long as that register
// is empty or is being drained in the same cycle; a stalled output holds the
// input side after one buffered run. The run of an accepted byte is on the
// output in the next cycle. tuser on the input marks the first byte of a new
// image, tlast its final byte. Bytes after the end of an image are dropped
// until the next start.
`include "assert_macros.svh"

module rle_sprite_run_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rsrd_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // data_byte
    input  logic                              s_axis_tuser,   // start_image
    input  logic                              s_axis_tlast,   // last_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rsrd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // run_x, run_y, run_length, color_index
    output rsrd_pkg::t_kind                   m_axis_tuser    // run_kind
);
    import rsrd_pkg::*;

    t_phase               r_phase, n_phase;
    logic [COORD_W-1:0]   r_cur_x, n_cur_x;
    logic [COORD_W-1:0]   r_cur_y, n_cur_y;
    logic [6:0]           r_lit_left, n_lit_left;
    logic [7:0]           r_pend, n_pend;
    logic                 r_done, n_done;

    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_run_x, r_run_y;
    logic [7:0]           r_run_len, r_run_color;
    t_kind                r_run_kind;

    t_phase               e_phase;
    logic [COORD_W-1:0]   e_cur_x, e_cur_y;
    logic [6:0]           e_lit_left;
    logic [7:0]           e_pend;
    logic                 e_done;

    logic                 emit;
    logic [7:0]           emit_len, emit_color;
    t_kind                emit_kind;
    logic                 accept;
    logic [7:0]           b;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // state as seen after an optional image start
    always_comb begin
        e_phase    = s_axis_tuser ? PH_OPCODE : r_phase;
        e_cur_x    = s_axis_tuser ? '0 : r_cur_x;
        e_cur_y    = s_axis_tuser ? '0 : r_cur_y;
        e_lit_left = s_axis_tuser ? '0 : r_lit_left;
        e_pend     = s_axis_tuser ? '0 : r_pend;
        e_done     = s_axis_tuser ? 1'b0 : r_done;
    end

    always_comb begin
        n_phase    = e_phase;
        n_cur_x    = e_cur_x;
        n_cur_y    = e_cur_y;
        n_lit_left = e_lit_left;
        n_pend     = e_pend;
        n_done     = e_done;
        emit       = 1'b0;
        emit_len   = '0;
        emit_kind  = KIND_COLOR;
        emit_color = '0;
        if (!e_done) begin
            unique case (e_phase)
                PH_LITERAL: begin
                    emit       = 1'b1;
                    emit_len   = 8'd1;
                    emit_color = b;
                    n_lit_left = e_lit_left - 7'd1;
                    if (n_lit_left == '0) begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_SHADOW1: begin
                    if (b[1:0] != 2'd0) begin
                        emit      = 1'b1;
                        emit_len  = {6'd0, b[1:0]};
                        emit_kind = KIND_SHADOW;
                        n_phase   = PH_OPCODE;
                    end else begin
                        n_phase = PH_SHADOW2;
                    end
                end
                PH_SHADOW2: begin
                    emit      = (b != 8'd0);
                    emit_len  = b;
                    emit_kind = KIND_SHADOW;
                    n_phase   = PH_OPCODE;
                end
                PH_COUNT: begin
                    n_pend  = b;
                    n_phase = PH_COLOR;
                end
                PH_COLOR: begin
                    emit       = (e_pend != 8'd0);
                    emit_len   = e_pend;
                    emit_color = b;
                    n_pend     = '0;
                    n_phase    = PH_OPCODE;
                end
                default: begin
                    n_phase = PH_OPCODE;
                    priority if (b == OP_END_ROW) begin
                        n_cur_y = e_cur_y + 16'd1;
                        n_cur_x = '0;
                    end else if (b < OP_END_IMAGE) begin
                        n_lit_left = b[6:0];
                        n_phase    = PH_LITERAL;
                    end else if (b == OP_END_IMAGE) begin
                        emit      = 1'b1;
                        emit_kind = KIND_END;
                        n_done    = 1'b1;
                    end else if (b < OP_SHADOW) begin
                        n_cur_x = e_cur_x + {9'd0, b[6:0]};
                    end else if (b == OP_SHADOW) begin
                        n_phase = PH_SHADOW1;
                    end else if (b == OP_COUNT) begin
                        n_phase = PH_COUNT;
                    end else begin
                        n_pend  = {2'd0, b[5:0]};
                        n_phase = PH_COLOR;
                    end
                end
            endcase
            if (emit) begin
                n_cur_x = e_cur_x + {8'd0, emit_len};
            end
            if (s_axis_tlast) begin
                n_done     = 1'b1;
                n_phase    = PH_OPCODE;
                n_lit_left = '0;
                n_pend     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPCODE;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_lit_left <= '0;
            r_pend     <= '0;
            r_done     <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_lit_left <= n_lit_left;
            r_pend     <= n_pend;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= accept && !e_done && emit;
        end
    end

    // run payload, loaded only when the output slot is free or drained in the same cycle
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_run_x     <= e_cur_x;
            r_run_y     <= e_cur_y;
            r_run_len   <= emit_len;
            r_run_kind  <= emit_kind;
            r_run_color <= emit_color;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_run_color, r_run_len, r_run_y, r_run_x};
    assign m_axis_tuser  = r_run_kind;

    `ASSERT_CLK(a_kind_legal, i_clk, i_rst_n, (r_out_valid |-> r_run_kind != KIND_RESV), "reserved run kind on output")
    `ASSERT_CLK(a_color_only, i_clk, i_rst_n, ((r_out_valid && r_run_kind != KIND_COLOR) |-> r_run_color == 8'd0), "color index on non-color run")
    `ASSERT_CLK(a_end_empty, i_clk, i_rst_n, ((r_out_valid && r_run_kind == KIND_END) |-> r_run_len == 8'd0), "end of image run with length")
    `ASSERT_NEXT(a_done_frozen, i_clk, i_rst_n, r_done && accept && !s_axis_tuser, $stable(r_cur_x) && $stable(r_cur_y) && $stable(r_phase) && r_done, "state changed after end of image")

endmodule

/* bench/testbench.sv */
// testbench for rle_sprite_run_decoder: queued byte driver, run predictor and output checker
module testbench;
    import rsrd_pkg::*;

    typedef struct packed {
        logic [7:0]  color;
        logic [7:0]  len;
        logic [15:0] y;
        logic [15:0] x;
    } t_run_word;

    typedef struct {
        t_run_word w;
        t_kind     kind;
    } t_run_due;

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       last;
        bit         drain;
    } t_sprite_byte;

    localparam int IDLE_PCT   = 24;
    localparam int HOLD_AT    = 700;
    localparam int HOLD_LEN   = 300;
    localparam int CALM_FROM  = 1200;
    localparam int CALM_TO    = 1500;
    localparam int STALL_MAX  = 5000;
    localparam int TAIL_WAIT  = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // data_byte
    logic                  s_axis_tuser = 1'b0; // start_image
    logic                  s_axis_tlast = 1'b0; // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // run_x, run_y, run_length, color_index
    t_kind                 m_axis_tuser;        // run_kind

    t_sprite_byte bytes_to_send[$];
    t_run_due     runs_due[$];

    bit          start_due = 1'b0;
    bit          drain_due = 1'b0;
    int unsigned bytes_taken = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned err_count = 0;
    bit          calm;

    // predictor state
    t_phase      dec_phase = PH_OPCODE;
    logic [15:0] cur_x = '0;
    logic [15:0] cur_y = '0;
    logic [6:0]  lit_left = '0;
    logic [7:0]  cnt_pending = '0;
    logic        img_done = 1'b0;

    rle_sprite_run_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    assign calm = (bytes_taken >= CALM_FROM) && (bytes_taken < CALM_TO);

    task automatic decode_byte(input logic [7:0] b, input logic st, input logic lst);
        t_run_due e;
        bit       hit;
        hit = 1'b0;
        e.kind = KIND_COLOR;
        e.w = '0;
        if (st) begin
            dec_phase = PH_OPCODE;
            cur_x = '0;
            cur_y = '0;
            lit_left = '0;
            cnt_pending = '0;
            img_done = 1'b0;
        end
        if (!img_done) begin
            case (dec_phase)
                PH_LITERAL: begin
                    hit = 1'b1;
                    e.w.len = 8'd1;
                    e.w.color = b;
                    lit_left = lit_left - 7'd1;
                    if (lit_left == 0) dec_phase = PH_OPCODE;
                end
                PH_SHADOW1: begin
                    if (b[1:0] != 2'd0) begin
                        hit = 1'b1;
                        e.kind = KIND_SHADOW;
                        e.w.len = {6'd0, b[1:0]};
                        dec_phase = PH_OPCODE;
                    end else begin
                        dec_phase = PH_SHADOW2;
                    end
                end
                PH_SHADOW2: begin
                    if (b != 8'd0) begin
                        hit = 1'b1;
                        e.kind = KIND_SHADOW;
                        e.w.len = b;
                    end
                    dec_phase = PH_OPCODE;
                end
                PH_COUNT: begin
                    cnt_pending = b;
                    dec_phase = PH_COLOR;
                end
                PH_COLOR: begin
                    if (cnt_pending != 8'd0) begin
                        hit = 1'b1;
                        e.w.len = cnt_pending;
                        e.w.color = b;
                    end
                    cnt_pending = '0;
                    dec_phase = PH_OPCODE;
                end
                default: begin
                    dec_phase = PH_OPCODE;
                    if (b == OP_END_ROW) begin
                        cur_y = cur_y + 16'd1;
                        cur_x = '0;
                    end else if (b < OP_END_IMAGE) begin
                        lit_left = b[6:0];
                        dec_phase = PH_LITERAL;
                    end else if (b == OP_END_IMAGE) begin
                        hit = 1'b1;
                        e.kind = KIND_END;
                        img_done = 1'b1;
                    end else if (b < OP_SHADOW) begin
                        cur_x = cur_x + {8'd0, b - OP_END_IMAGE};
                    end else if (b == OP_SHADOW) begin
                        dec_phase = PH_SHADOW1;
                    end else if (b == OP_COUNT) begin
                        dec_phase = PH_COUNT;
                    end else begin
                        cnt_pending = b - OP_SHADOW;
                        dec_phase = PH_COLOR;
                    end
                end
            endcase
            if (hit) begin
                e.w.x = cur_x;
                e.w.y = cur_y;
                runs_due.push_back(e);
                cur_x = cur_x + {8'd0, e.w.len};
            end
            if (lst) begin
                img_done = 1'b1;
                dec_phase = PH_OPCODE;
                lit_left = '0;
                cnt_pending = '0;
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input bit st = 1'b0, input bit lst = 1'b0);
        t_sprite_byte it;
        it.data = b;
        it.start = st | start_due;
        it.last = lst;
        it.drain = drain_due;
        start_due = 1'b0;
        drain_due = 1'b0;
        bytes_to_send.push_back(it);
    endtask

    // one well-formed opcode with random content, or a stray byte
    task automatic add_op();
        int         r;
        int         n;
        logic [7:0] b;
        r = $urandom_range(99);
        if (r < 25) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(127, 1) : $urandom_range(6, 1);
            push_byte(n[7:0]);
            repeat (n) push_byte(8'($urandom_range(255)));
        end else if (r < 35) begin
            push_byte(OP_END_ROW);
        end else if (r < 45) begin
            push_byte(8'($urandom_range(8'hBF, 8'h81)));
        end else if (r < 60) begin
            push_byte(OP_SHADOW);
            b = 8'($urandom_range(255));
            if ($urandom_range(9) < 4) b[1:0] = 2'd0;
            push_byte(b);
            if (b[1:0] == 2'd0)
                push_byte(($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(255)));
        end else if (r < 75) begin
            push_byte(OP_COUNT);
            push_byte(($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(255)));
            push_byte(8'($urandom_range(255)));
        end else if (r < 95) begin
            push_byte(8'($urandom_range(8'hFF, 8'hC2)));
            push_byte(8'($urandom_range(255)));
        end else begin
            push_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic add_image(input bit drain_first);
        int n_ops;
        int ending;
        start_due = 1'b1;
        drain_due = drain_first;
        n_ops = $urandom_range(12);
        ending = $urandom_range(2);
        repeat (n_ops) add_op();
        case (ending)
            0: begin
                push_byte(OP_END_IMAGE);
                repeat ($urandom_range(3))
                    push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
            end
            1: begin
                push_byte(8'($urandom_range(255)), 1'b0, 1'b1);
                repeat ($urandom_range(2))
                    push_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
            end
            default: begin
                // cut off inside a run, the next start interrupts it
                push_byte(8'($urandom_range(8'hFF, 8'hC0)));
            end
        endcase
    endtask

    task automatic fill_random(input int upto);
        int img_cnt;
        img_cnt = 0;
        while (bytes_to_send.size() < upto) begin
            add_image(img_cnt % 8 == 0);
            img_cnt++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        bit           took;
        t_sprite_byte nxt;
        took = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            s_axis_tlast <= 1'b0;
        end else begin
            if (took) begin
                decode_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
                bytes_taken <= bytes_taken + 1;
            end
            if (!s_axis_tvalid || took) begin
                if (bytes_to_send.size() != 0
                        && (hold_left != 0 || calm || $urandom_range(99) >= IDLE_PCT)
                        && !(bytes_to_send[0].drain && runs_due.size() != 0)) begin
                    nxt = bytes_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt.data;
                    s_axis_tuser <= nxt.start;
                    s_axis_tlast <= nxt.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && bytes_taken >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_run_word got;
        t_run_due  want;
        got = m_axis_tdata;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (runs_due.size() == 0) begin
                $display("%0t: unexpected run x=%0d y=%0d len=%0d kind=%0d color=%0d",
                         $time, got.x, got.y, got.len, m_axis_tuser, got.color);
                err_count <= err_count + 1;
            end else begin
                want = runs_due.pop_front();
                if (got != want.w || m_axis_tuser != want.kind) begin
                    $display("%0t: run mismatch expected x=%0d y=%0d len=%0d kind=%0d color=%0d",
                             $time, want.w.x, want.w.y, want.w.len, want.kind, want.w.color);
                    $display("%0t:              actual x=%0d y=%0d len=%0d kind=%0d color=%0d",
                             $time, got.x, got.y, got.len, m_axis_tuser, got.color);
                    err_count <= err_count + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("rle_sprite_run_decoder verification failed");
            $finish;
        end
    end

    initial begin : stim
        int base;
        // directed
        push_byte(8'hC2, 1'b1);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(OP_END_ROW);
        push_byte(8'h01);
        push_byte(8'h5A);
        push_byte(8'h81);
        push_byte(8'hBF);
        push_byte(OP_SHADOW);
        push_byte(8'h03);
        push_byte(OP_SHADOW);
        push_byte(8'h04);
        push_byte(8'h00);
        push_byte(OP_SHADOW);
        push_byte(8'h08);
        push_byte(8'hFF);
        push_byte(OP_COUNT);
        push_byte(8'h00);
        push_byte(8'h55);
        push_byte(OP_COUNT);
        push_byte(8'hFF);
        push_byte(8'hAA);
        push_byte(OP_END_IMAGE);
        push_byte(8'h12);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'h05, 1'b1);
        push_byte(8'h11);
        push_byte(8'h22, 1'b0, 1'b1);
        push_byte(8'h44);
        push_byte(OP_END_IMAGE, 1'b1, 1'b1);
        push_byte(8'h7F, 1'b1, 1'b1);

        // random images, with a long one that wraps the column
        base = bytes_to_send.size();
        fill_random(base + 600);
        start_due = 1'b1;
        drain_due = 1'b1;
        repeat (260) begin
            push_byte(OP_COUNT);
            push_byte(8'hFF);
            push_byte(8'($urandom_range(255)));
        end
        push_byte(OP_END_IMAGE);
        fill_random(bytes_to_send.size() + 600);

        while (bytes_to_send.size() != 0 || s_axis_tvalid || runs_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("rle_sprite_run_decoder verification clean");
        else
            $display("rle_sprite_run_decoder verification failed");
        $finish;
    end

endmodule
